### hdl/fqr_pkg.sv
// Shared types and codes for the process identifier queue with remove-by-key.
package fqr_pkg;

  // Fixed field widths of the request and result payloads.
  localparam int ID_W  = 16;
  localparam int OCC_W = 5;

  // Operation codes.
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] process_id;
  } fqr_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  out_id;
    logic [1:0]       status;
    logic             queue_empty;
    logic [OCC_W-1:0] occupancy;
  } fqr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_SCAN,
    S_RESULT
  } fqr_state_t;

endpackage

### hdl/fifo_queue_with_remove.sv
// Process identifier queue with enqueue, dequeue and remove-by-identifier requests.
// An accepted request passes through S_EXEC and then S_RESULT for an enqueue or on an empty queue,
// with S_DEQ between them for a dequeue and S_SCAN for a remove, which reads one entry per cycle.
// The next request is taken only once the result has reached the output register, and a
// stalled result holds off the input.
// Reset is synchronous and active low: the queue comes up empty and the memory is not cleared.
module fifo_queue_with_remove
  import fqr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fqr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fqr_out_t out_data
);

  // The queue is a circular buffer in one memory. A remove scans from the head and, once the
  // matching entry is found, copies every following entry one place toward the head, which
  // keeps the order and closes the gap in the same pass.
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) begin
      r = AW'(QUEUE_DEPTH - 1);
    end else begin
      r = a - AW'(1);
    end
    return r;
  endfunction

  fqr_state_t state_r, state_nxt;
  logic [1:0]    op_r;
  logic [EW-1:0] pid_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_n_r, rd_n_nxt;     // entries read so far in a scan
  logic          dv_r, dv_nxt;         // memory data this cycle belongs to a scan read
  logic [AW-1:0] dpos_r, dpos_nxt;     // queue position of that data
  logic [AW-1:0] daddr_r, daddr_nxt;   // memory slot of that data
  logic          found_r, found_nxt;
  fqr_out_t      res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  fqr_out_t      out_data_r, out_data_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_q;

  logic q_empty, q_full, out_free, is_match, is_last;

  fqr_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(EW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_q)
  );

  assign q_empty  = (cnt_r == '0);
  assign q_full   = (cnt_r == CW'(QUEUE_DEPTH));
  assign out_free = !out_valid_r || !out_stall;
  assign is_match = dv_r && (mem_q == pid_r);
  // The scan ends when the entry at the last occupied position comes back from memory.
  assign is_last  = dv_r && ({1'b0, dpos_r} == (AW + 1)'(cnt_r - CW'(1)));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_DEQUEUE: state_nxt = q_empty ? S_RESULT : S_DEQ;
          OP_REMOVE:  state_nxt = q_empty ? S_RESULT : S_SCAN;
          default:    state_nxt = S_RESULT;
        endcase
      end
      S_DEQ: state_nxt = S_RESULT;
      S_SCAN: begin
        if (is_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory control and result.
  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    rd_n_nxt      = rd_n_r;
    dv_nxt        = 1'b0;
    dpos_nxt      = dpos_r;
    daddr_nxt     = daddr_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = pid_r;
    mem_re        = 1'b0;
    mem_raddr     = head_r;

    unique case (state_r)
      S_EXEC: begin
        rd_n_nxt  = '0;
        found_nxt = 1'b0;
        res_nxt   = '{out_id: '0, status: ST_MISS, queue_empty: q_empty,
                      occupancy: OCC_W'(cnt_r)};
        unique case (op_r)
          OP_ENQUEUE: begin
            if (q_full) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_add(head_r, AW'(cnt_r));
              cnt_nxt   = cnt_r + CW'(1);
              res_nxt   = '{out_id: '0, status: ST_DONE, queue_empty: 1'b0,
                            occupancy: OCC_W'(cnt_r + CW'(1))};
            end
          end
          OP_DEQUEUE: begin
            mem_re = !q_empty;
          end
          default: begin
          end
        endcase
      end
      S_DEQ: begin
        head_nxt = slot_add(head_r, AW'(1));
        cnt_nxt  = cnt_r - CW'(1);
        res_nxt  = '{out_id: ID_W'(mem_q), status: ST_DONE,
                     queue_empty: (cnt_r == CW'(1)),
                     occupancy: OCC_W'(cnt_r - CW'(1))};
      end
      S_SCAN: begin
        // Read side: one entry per cycle, in queue order.
        if (rd_n_r < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = slot_add(head_r, AW'(rd_n_r));
          rd_n_nxt  = rd_n_r + CW'(1);
          dv_nxt    = 1'b1;
          dpos_nxt  = AW'(rd_n_r);
          daddr_nxt = mem_raddr;
        end
        // Data side: after the match, every entry moves one slot toward the head.
        if (dv_r) begin
          if (found_r) begin
            mem_we    = 1'b1;
            mem_waddr = slot_dec(daddr_r);
            mem_wdata = mem_q;
          end else if (is_match) begin
            found_nxt = 1'b1;
          end
        end
        if (is_last) begin
          if (found_r || is_match) begin
            cnt_nxt = cnt_r - CW'(1);
            res_nxt = '{out_id: '0, status: ST_DONE, queue_empty: (cnt_r == CW'(1)),
                        occupancy: OCC_W'(cnt_r - CW'(1))};
          end else begin
            res_nxt = '{out_id: '0, status: ST_MISS, queue_empty: 1'b0,
                        occupancy: OCC_W'(cnt_r)};
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      rd_n_r      <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      rd_n_r      <= rd_n_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r  <= in_data.op;
      pid_r <= in_data.process_id[EW-1:0];
    end
    dpos_r     <= dpos_nxt;
    daddr_r    <= daddr_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  // The occupancy never goes past the depth of the memory.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy exceeds depth");

  // A compaction write never lands on the slot being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write collide on one slot");

  // A result only appears on the output after the staging state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESULT)
    else $error("result presented without a finished request");

  // The occupancy changes only while a request is being worked on.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      ($past(state_r) == S_EXEC || $past(state_r) == S_DEQ || $past(state_r) == S_SCAN))
    else $error("occupancy changed outside request processing");
`endif

endmodule

### hdl/fqr_mem.sv
// Single-port-write, single-port-read memory with a registered read.
module fqr_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
